/* sv/sldt_pkg.sv */
// ----------------------------------------------------------------------------
// sldt_pkg: shared definitions for the seeded line distance transform
// Field widths, parameter defaults, control groups and a min helper.
// ----------------------------------------------------------------------------
package sldt_pkg;

  localparam int POS_W        = 6;
  localparam int SVAL_W       = 30;
  localparam int CVAL_W       = 31;
  localparam int CFG_W        = 7;
  localparam int CELLS_DEF    = 64;
  localparam int VBITS_DEF    = 31;
  localparam logic [CFG_W-1:0] LEN_RESET = 7'd64;

  typedef struct packed {
    logic clear;
    logic wr_en;
    logic rd_en;
  } seed_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
  } cost_ctrl_t;

  function automatic logic [63:0] min64(input logic [63:0] a, input logic [63:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

/* sv/sldt_if.sv */
// ----------------------------------------------------------------------------
// sldt_if: request channels of the seeded line distance transform
// Seed channel in, cell result channel out, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sldt_seed_if import sldt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  seed_position;
  logic [SVAL_W-1:0] seed_value;
  logic              seed_last;

  modport source (output valid, seed_position, seed_value, seed_last, input ready);
  modport sink   (input valid, seed_position, seed_value, seed_last, output ready);
endinterface

interface sldt_cell_if import sldt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cell_index;
  logic [CVAL_W-1:0] cell_value;
  logic              cell_last;

  modport source (output valid, cell_index, cell_value, cell_last, input ready);
  modport sink   (input valid, cell_index, cell_value, cell_last, output ready);
endinterface

/* sv/sldt_seed_store.sv */
// ----------------------------------------------------------------------------
// sldt_seed_store: per-cell seed memory
// One write and one registered read port; valid flops make unwritten cells
// read as infinity and clear the whole store at once.
// ----------------------------------------------------------------------------
module sldt_seed_store import sldt_pkg::*; #(
  parameter int MAX_CELLS  = CELLS_DEF,
  parameter int VALUE_BITS = VBITS_DEF,
  localparam int IDX_W     = $clog2(MAX_CELLS)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  seed_ctrl_t            ctrl,
  input  logic [IDX_W-1:0]      wr_addr,
  input  logic [VALUE_BITS-1:0] wr_data,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic [VALUE_BITS-1:0] rd_data
);

  logic [VALUE_BITS-1:0] mem [MAX_CELLS];
  logic [MAX_CELLS-1:0]  vld;
  logic [VALUE_BITS-1:0] q;
  logic                  q_ok;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      vld  <= '0;
      q_ok <= 1'b0;
    end else begin
      if (ctrl.wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        q_ok <= vld[rd_addr];
      end
    end
  end

  assign rd_data = q_ok ? q : '1;

endmodule

/* sv/sldt_cost_unit.sv */
// ----------------------------------------------------------------------------
// sldt_cost_unit: shared saturating cost step
// Holds the running cost; one step adds one cell of distance, saturating, and
// takes the minimum with the seed at that cell; best also with a side cost.
// ----------------------------------------------------------------------------
module sldt_cost_unit import sldt_pkg::*; #(
  parameter int VALUE_BITS = VBITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cost_ctrl_t            ctrl,
  input  logic [VALUE_BITS-1:0] seed_cost,
  input  logic [VALUE_BITS-1:0] side_cost,
  output logic [VALUE_BITS-1:0] cost_next,
  output logic [VALUE_BITS-1:0] best
);

  logic [VALUE_BITS-1:0] running;
  logic [VALUE_BITS-1:0] inc;

  assign inc       = (&running) ? running : running + 1'b1;
  assign cost_next = VALUE_BITS'(min64(64'(inc), 64'(seed_cost)));
  assign best      = VALUE_BITS'(min64(64'(cost_next), 64'(side_cost)));

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      running <= '1;
    end else if (ctrl.step) begin
      running <= cost_next;
    end
  end

endmodule

/* sv/seeded_line_distance_transform.sv */
// ----------------------------------------------------------------------------
// seeded_line_distance_transform: L1 distance transform over a seeded strip
// Collects seeds, then runs a backward and a forward pass through one shared
// cost unit and streams one result per cell.
//
//   channel  dir  handshake         payload
//   seed     in   valid/ready       seed_position, seed_value, seed_last
//   result   out  valid/ready       cell_index, cell_value, cell_last
//   cfg      in   cfg_we            cfg_wdata (strip_length)
//
// A seed inside the strip is read in LOAD and merged in MERGE; one outside
// is taken in LOAD alone. The last seed starts the backward pass, then the
// forward pass, which the result sink can stall; the seed store memory port
// sets one cell per cycle while the sink does not stall. seed.ready is low
// during both passes. Reset is synchronous; it empties the seed store at once.
// ----------------------------------------------------------------------------
module seeded_line_distance_transform import sldt_pkg::*; #(
  parameter int MAX_CELLS  = CELLS_DEF,
  parameter int VALUE_BITS = VBITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  sldt_seed_if.sink         seed,
  sldt_cell_if.source       result,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_CELLS);
  localparam int CNT_W = $clog2(MAX_CELLS + 1);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_MERGE = 4'b0010,
    ST_BACK  = 4'b0100,
    ST_FWD   = 4'b1000
  } state_t;

  state_t                state, state_next;
  logic [CFG_W-1:0]      strip_length;
  logic [CNT_W-1:0]      len_eff;
  logic [IDX_W-1:0]      last_cell;
  logic [CNT_W-1:0]      rem, rem_next;
  logic [IDX_W-1:0]      addr, addr_next;
  logic                  s1_valid, s1_valid_next;
  logic [IDX_W-1:0]      s1_cell;
  logic [IDX_W-1:0]      ld_pos;
  logic [VALUE_BITS-1:0] ld_val;
  logic                  ld_last;
  logic                  accept, in_strip, issue, adv, fwd_step;
  logic [VALUE_BITS-1:0] in_val;
  logic [IDX_W-1:0]      rd_addr;
  logic [VALUE_BITS-1:0] seed_rd;
  logic [VALUE_BITS-1:0] right_mem [MAX_CELLS];
  logic [VALUE_BITS-1:0] right_q;
  logic [VALUE_BITS-1:0] cost_next, best;
  logic [VALUE_BITS-1:0] merge_val;
  seed_ctrl_t            sctrl;
  cost_ctrl_t            cctrl;
  logic                  out_valid;
  logic [POS_W-1:0]      out_index;
  logic [CVAL_W-1:0]     out_value;
  logic                  out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      strip_length <= LEN_RESET;
    end else if (cfg_we) begin
      strip_length <= cfg_wdata;
    end
  end

  always_comb begin
    if (strip_length == '0) begin
      len_eff = CNT_W'(1);
    end else if (strip_length > CFG_W'(MAX_CELLS)) begin
      len_eff = CNT_W'(MAX_CELLS);
    end else begin
      len_eff = CNT_W'(strip_length);
    end
  end

  assign last_cell = IDX_W'(len_eff - 1'b1);
  assign accept    = seed.valid && seed.ready;
  assign in_strip  = CFG_W'(seed.seed_position) < CFG_W'(len_eff);
  assign in_val    = VALUE_BITS'(64'(seed.seed_value));
  assign adv       = !out_valid || result.ready;
  assign merge_val = VALUE_BITS'(min64(64'(seed_rd), 64'(ld_val)));

  always_comb begin
    issue = 1'b0;
    case (state)
      ST_BACK: issue = (rem != '0);
      ST_FWD:  issue = (rem != '0) && (!s1_valid || adv);
      default: issue = 1'b0;
    endcase
  end

  assign fwd_step = (state == ST_FWD) && s1_valid && adv;
  assign rd_addr  = (state == ST_LOAD) ? IDX_W'(seed.seed_position) : addr;

  always_comb begin
    state_next    = state;
    rem_next      = rem;
    addr_next     = addr;
    s1_valid_next = 1'b0;
    cctrl         = '0;
    sctrl         = '0;
    sctrl.rd_en   = issue || (accept && in_strip);
    case (state)
      ST_LOAD: begin
        if (accept && in_strip) begin
          state_next = ST_MERGE;
        end else if (accept && seed.seed_last) begin
          state_next  = ST_BACK;
          rem_next    = len_eff;
          addr_next   = last_cell;
          cctrl.clear = 1'b1;
        end
      end
      ST_MERGE: begin
        sctrl.wr_en = 1'b1;
        if (ld_last) begin
          state_next  = ST_BACK;
          rem_next    = len_eff;
          addr_next   = last_cell;
          cctrl.clear = 1'b1;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_BACK: begin
        cctrl.step    = s1_valid;
        s1_valid_next = issue;
        if (issue) begin
          rem_next  = rem - 1'b1;
          addr_next = addr - 1'b1;
        end else if (!s1_valid) begin
          state_next  = ST_FWD;
          rem_next    = len_eff;
          addr_next   = '0;
          cctrl.clear = 1'b1;
        end
      end
      ST_FWD: begin
        cctrl.step    = fwd_step;
        s1_valid_next = issue || (s1_valid && !adv);
        if (issue) begin
          rem_next  = rem - 1'b1;
          addr_next = addr + 1'b1;
        end else if (rem == '0 && !s1_valid) begin
          state_next  = ST_LOAD;
          cctrl.clear = 1'b1;
          sctrl.clear = 1'b1;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      rem      <= '0;
      addr     <= '0;
      s1_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rem      <= rem_next;
      addr     <= addr_next;
      s1_valid <= s1_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ld_pos  <= IDX_W'(seed.seed_position);
      ld_val  <= in_val;
      ld_last <= seed.seed_last;
    end
    if (issue) begin
      s1_cell <= addr;
    end
  end

  sldt_seed_store #(
    .MAX_CELLS  (MAX_CELLS),
    .VALUE_BITS (VALUE_BITS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (sctrl),
    .wr_addr (ld_pos),
    .wr_data (merge_val),
    .rd_addr (rd_addr),
    .rd_data (seed_rd)
  );

  sldt_cost_unit #(
    .VALUE_BITS (VALUE_BITS)
  ) u_cost (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (cctrl),
    .seed_cost (seed_rd),
    .side_cost (right_q),
    .cost_next (cost_next),
    .best      (best)
  );

  always_ff @(posedge clk) begin
    if (state == ST_BACK && s1_valid) begin
      right_mem[s1_cell] <= cost_next;
    end
    if (issue) begin
      right_q <= right_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fwd_step) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fwd_step) begin
      out_index <= POS_W'(s1_cell);
      out_value <= CVAL_W'(64'(best));
      out_last  <= (s1_cell == last_cell);
    end
  end

  assign seed.ready        = (state == ST_LOAD);
  assign result.valid      = out_valid;
  assign result.cell_index = out_index;
  assign result.cell_value = out_value;
  assign result.cell_last  = out_last;

  a_s1_in_pass: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> (state == ST_BACK || state == ST_FWD))
    else $error("read stage busy outside a pass");

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    rem <= len_eff)
    else $error("remaining cell count above strip length");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FWD && s1_valid && !adv) |=> s1_valid)
    else $error("read stage dropped while output stalled");

  a_fwd_after_back: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_FWD) |-> $past(state == ST_BACK))
    else $error("forward pass entered without backward pass");

endmodule
